### rtl/rfc_pkg.sv
// rfc_pkg: shared types and codes of the retry frame cache filter
// no dependencies; used by retry_frame_cache_filter
package rfc_pkg;

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_MISS   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
	localparam logic [1:0] CFG_BCAST_ID = 2'd1;
	localparam logic [1:0] CFG_REPLAY_A = 2'd2;
	localparam logic [1:0] CFG_REPLAY_B = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] cmd_id;
		logic [15:0] seq_number;
		logic [7:0]  protocol;
		logic [8:0]  frame_len;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [2:0]  read_slot;
		logic [7:0]  read_offset;
	} rfc_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic       duplicate;
		logic       replay;
		logic [2:0] hit_slot;
		logic [8:0] hit_len;
		logic [7:0] hit_protocol;
		logic [7:0] read_data;
	} rfc_out_t;

endpackage

### rtl/rfc_chan_if.sv
// rfc_chan_if: valid/ready channel carrying one payload per transaction
// payload type is a parameter; types come from rfc_pkg
interface rfc_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/rfc_bank.sv
// rfc_bank: one frame store bank, one write and one registered read port
// no dependencies
module rfc_bank #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### rtl/retry_frame_cache_filter.sv
// retry_frame_cache_filter: ring of cached frames with retry/duplicate filter
// depends on rfc_pkg, rfc_chan_if and rfc_bank
//
// channel | dir | handshake     | payload
// req     | in  | valid/ready   | rfc_in_t  (kind, ids, length, byte, read address)
// res     | out | valid/ready   | rfc_out_t (status, filter answer, hit fields, read byte)
// cfg     | in  | cfg_we        | cfg_idx, cfg_wdata
//
// tick and store items complete on acceptance; a read waits in S_RD for the
// registered bank read. a broadcast query byte reads all banks at the byte
// position and compares them in the next cycle. a last query byte then scans
// the slot table one slot per cycle while the output register is free, up to the
// first hit or a miss at the last slot. reset clears valid bits and counters and
// resets config; banks are not cleared. a waiting result stalls input and the scan.
module retry_frame_cache_filter
	import rfc_pkg::*;
#(
	parameter int SLOTS     = 8,
	parameter int FRAME_MAX = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	rfc_chan_if.sink    req,
	rfc_chan_if.source  res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);
	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int AW  = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
	localparam int BPW = $clog2(FRAME_MAX + 1);
	localparam int CW  = (BPW > 9) ? BPW : 9;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_RD   = 2'd3;

	// configuration registers
	logic [15:0] timeout_q, bcast_id_q, replay_a_q, replay_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= 16'd30;
			bcast_id_q <= 16'd0;
			replay_a_q <= 16'd1;
			replay_b_q <= 16'd2;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TIMEOUT:  timeout_q  <= cfg_wdata;
				CFG_BCAST_ID: bcast_id_q <= cfg_wdata;
				CFG_REPLAY_A: replay_a_q <= cfg_wdata;
				CFG_REPLAY_B: replay_b_q <= cfg_wdata;
				default:      timeout_q  <= timeout_q;
			endcase
		end
	end

	// control state
	logic [1:0]       state_q;
	logic [SLOTS-1:0] slot_valid_q;
	logic [SLOTS-1:0] still_eq_q;
	logic [SW-1:0]    wp_q;
	logic [SW-1:0]    scan_q;
	logic [31:0]      sec_q;
	logic [BPW-1:0]   bp_q;
	logic             out_vld_q;

	// slot table and query context
	logic [15:0] slot_cmd_q   [SLOTS];
	logic [15:0] slot_seq_q   [SLOTS];
	logic [7:0]  slot_proto_q [SLOTS];
	logic [8:0]  slot_len_q   [SLOTS];
	logic [31:0] slot_time_q  [SLOTS];
	logic [15:0] q_cmd_q, q_seq_q;
	logic [8:0]  q_len_q;
	logic        q_bc_q, q_last_q;
	logic [7:0]  q_byte_q;
	logic [AW-1:0] addr_q;
	logic [2:0]  rd_slot_q;
	logic        rd_ok_q;
	rfc_out_t    res_q;

	// handshake
	logic out_free, acc;
	assign out_free  = !out_vld_q || res.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign res.valid = out_vld_q;
	assign res.payload = res_q;

	// item decode
	rfc_in_t  it;
	logic     bp_room, len_ok, is_bc;
	assign it      = req.payload;
	assign bp_room = CW'(bp_q) < CW'(FRAME_MAX);
	assign len_ok  = CW'(it.frame_len) <= CW'(FRAME_MAX);
	assign is_bc   = it.cmd_id == bcast_id_q;

	// frame store banks
	logic [AW-1:0] raddr;
	logic [7:0]    rdata [SLOTS];
	logic          st_write;
	assign st_write = acc && (it.kind == KIND_STORE) && bp_room && len_ok;
	assign raddr = (state_q != S_IDLE) ? addr_q :
		(it.kind == KIND_READ) ? AW'(it.read_offset) : bp_q[AW-1:0];

	for (genvar g = 0; g < SLOTS; g++) begin : g_bank
		rfc_bank #(.DEPTH(FRAME_MAX), .AW(AW)) u_bank (
			.clk   (clk),
			.we    (st_write && (int'(wp_q) == g)),
			.waddr (bp_q[AW-1:0]),
			.wdata (it.data_byte),
			.raddr (raddr),
			.rdata (rdata[g])
		);
	end

	// byte compare and read select
	logic [SLOTS-1:0] cmp_ne;
	logic [7:0]       rd_byte;
	always_comb begin
		rd_byte = 8'd0;
		for (int i = 0; i < SLOTS; i++) begin
			cmp_ne[i] = rdata[i] != q_byte_q;
			if (int'(rd_slot_q) == i) rd_byte = rdata[i];
		end
	end

	// current scan slot
	logic scan_stale, scan_match, scan_end, is_reply;
	always_comb begin
		scan_stale = {1'b0, sec_q} > ({1'b0, slot_time_q[scan_q]} + 33'(timeout_q));
		if (q_bc_q) scan_match = (slot_len_q[scan_q] == q_len_q) && still_eq_q[scan_q];
		else        scan_match = (slot_cmd_q[scan_q] == q_cmd_q) &&
			                     (slot_seq_q[scan_q] == q_seq_q);
		scan_end = scan_q == SW'(SLOTS - 1);
		is_reply = (q_cmd_q == replay_a_q) || (q_cmd_q == replay_b_q);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			addr_q    <= raddr;
			q_cmd_q   <= it.cmd_id;
			q_seq_q   <= it.seq_number;
			q_len_q   <= it.frame_len;
			q_bc_q    <= is_bc;
			q_last_q  <= it.last_byte;
			q_byte_q  <= it.data_byte;
			rd_slot_q <= it.read_slot;
			rd_ok_q   <= (32'(it.read_slot) < 32'(SLOTS)) &&
			             (32'(it.read_offset) < 32'(FRAME_MAX));
		end
		if (acc && it.kind == KIND_STORE && it.last_byte && len_ok) begin
			slot_cmd_q[wp_q]   <= it.cmd_id;
			slot_seq_q[wp_q]   <= it.seq_number;
			slot_proto_q[wp_q] <= it.protocol;
			slot_len_q[wp_q]   <= it.frame_len;
			slot_time_q[wp_q]  <= sec_q;
		end
		if (state_q == S_SCAN && out_free && slot_valid_q[scan_q] &&
		    !scan_stale && scan_match) begin
			slot_time_q[scan_q] <= sec_q;
		end
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			still_eq_q   <= '1;
			wp_q         <= '0;
			scan_q       <= '0;
			sec_q        <= '0;
			bp_q         <= '0;
			out_vld_q    <= 1'b0;
			res_q        <= '0;
		end else begin
			if (res.ready) out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (it.kind)
							KIND_TICK: sec_q <= sec_q + 32'd1;
							KIND_STORE: begin
								if (bp_room) begin
									if (len_ok) slot_valid_q[wp_q] <= 1'b0;
									bp_q <= bp_q + BPW'(1);
								end
								if (it.last_byte) begin
									bp_q      <= '0;
									out_vld_q <= 1'b1;
									res_q     <= '0;
									if (!len_ok) begin
										res_q.status <= ST_REJECT;
									end else begin
										res_q.status       <= ST_OK;
										slot_valid_q[wp_q] <= 1'b1;
										wp_q <= (wp_q == SW'(SLOTS - 1)) ? '0 : wp_q + SW'(1);
									end
								end
							end
							KIND_QUERY: begin
								scan_q <= '0;
								if (is_bc && bp_room) begin
									bp_q <= bp_q + BPW'(1);
									if (CW'(bp_q) < CW'(it.frame_len)) state_q <= S_CMP;
									else if (it.last_byte)             state_q <= S_SCAN;
								end else if (it.last_byte) begin
									state_q <= S_SCAN;
								end
							end
							KIND_READ: state_q <= S_RD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CMP: begin
					still_eq_q <= still_eq_q & ~cmp_ne;
					state_q    <= q_last_q ? S_SCAN : S_IDLE;
				end
				S_SCAN: begin
					if (out_free) begin
						if (slot_valid_q[scan_q] && scan_stale) begin
							slot_valid_q[scan_q] <= 1'b0;
						end
						if (slot_valid_q[scan_q] && !scan_stale && scan_match) begin
							out_vld_q          <= 1'b1;
							res_q              <= '0;
							res_q.status       <= ST_OK;
							res_q.duplicate    <= q_bc_q || is_reply;
							res_q.replay       <= !q_bc_q && is_reply;
							res_q.hit_slot     <= 3'(scan_q);
							res_q.hit_len      <= slot_len_q[scan_q];
							res_q.hit_protocol <= slot_proto_q[scan_q];
							state_q            <= S_IDLE;
						end else if (scan_end) begin
							out_vld_q    <= 1'b1;
							res_q        <= '0;
							res_q.status <= ST_MISS;
							state_q      <= S_IDLE;
						end else begin
							scan_q <= scan_q + SW'(1);
						end
						if ((slot_valid_q[scan_q] && !scan_stale && scan_match) || scan_end) begin
							if (q_bc_q) begin
								bp_q       <= '0;
								still_eq_q <= '1;
							end
						end
					end
				end
				S_RD: begin
					if (out_free) begin
						out_vld_q       <= 1'b1;
						res_q           <= '0;
						res_q.status    <= ST_OK;
						res_q.read_data <= rd_ok_q ? rd_byte : 8'd0;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready)
		else $error("input accepted while busy");

	a_cmp_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_IDLE))
		else $error("compare cycle without a query byte");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && it.kind == KIND_STORE && it.last_byte && len_ok)
		|=> slot_valid_q[$past(wp_q)] && out_vld_q)
		else $error("committed slot not valid");

	a_scan_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !out_free) |=> (state_q == S_SCAN) && $stable(scan_q))
		else $error("scan moved while result stalled");
endmodule
